[src/dq_pkg.sv]
`timescale 1ns / 1ps

package dq_pkg;

  // Field widths of the request and result words.
  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int OCC_W  = 11;
  localparam int STAT_W = 2;

  // Stream word widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 1024;
  localparam int ITEM_WIDTH_DEF = 32;

  // Operation requested.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_READ_IDX   = 3'd6,
    MODE_WRITE_IDX  = 3'd7
  } mode_t;

  // Result status.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Result fields known when the request is decoded.
  typedef struct packed {
    logic             rd;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } meta_t;

endpackage

[src/dq_ram.sv]
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[src/dq_ctrl.sv]
`timescale 1ns / 1ps

module dq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  dq_pkg::mode_t               mode,
  input  logic [dq_pkg::DATA_W-1:0]   item,
  input  logic [dq_pkg::IDX_W-1:0]    index,
  output logic                        mem_en,
  output logic                        mem_we,
  output logic [$clog2(DEPTH)-1:0]    mem_addr,
  output logic [ITEM_WIDTH-1:0]       mem_wdata,
  output dq_pkg::meta_t               meta
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + IDX_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] offset;
  logic [AW:0]   sum;
  logic [AW-1:0] slot;
  logic          full;
  logic          empty;
  logic          in_range;
  logic          access;
  logic          write;
  logic          use_front_dec;
  logic          rd;
  status_t       status;

  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);
  assign in_range = (XW'(index) < XW'(count));

  // Physical slot of a logical position: one compare and subtract.
  assign sum  = {1'b0, front} + {1'b0, offset};
  assign slot = (sum >= DEPTH_A) ? AW'(sum - DEPTH_A) : AW'(sum);

  // Decode the request against the current front and count.
  always_comb begin
    offset        = '0;
    front_next    = front;
    count_next    = count;
    access        = 1'b0;
    write         = 1'b0;
    use_front_dec = 1'b0;
    rd            = 1'b0;
    status        = ST_OK;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          access        = 1'b1;
          write         = 1'b1;
          use_front_dec = 1'b1;
          front_next    = (front == '0) ? LAST_A : front - 1'b1;
          count_next    = count + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        offset = AW'(count);
        if (full) begin
          status = ST_FULL;
        end else begin
          access     = 1'b1;
          write      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        offset = AW'(1);
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          access = 1'b1;
          rd     = 1'b1;
          if (mode == MODE_POP_FRONT) begin
            front_next = slot;
            count_next = count - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        offset = AW'(count - 1'b1);
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          access = 1'b1;
          rd     = 1'b1;
          if (mode == MODE_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      MODE_READ_IDX, MODE_WRITE_IDX: begin
        offset = AW'(index);
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          access = 1'b1;
          write  = (mode == MODE_WRITE_IDX);
          rd     = (mode == MODE_READ_IDX);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Memory access; the front reads sit at the current front slot.
  always_comb begin
    mem_en    = fire && access;
    mem_we    = write;
    mem_wdata = ITEM_WIDTH'(item);
    if (use_front_dec) begin
      mem_addr = front_next;
    end else if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
      mem_addr = front;
    end else begin
      mem_addr = slot;
    end
  end

  assign meta.rd        = rd;
  assign meta.status    = status;
  assign meta.occupancy = OCC_W'(count_next);

  // Front position and stored count.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (fire) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

[src/deque_with_indexed_access.sv]
`timescale 1ns / 1ps

// Double-ended queue of data words in one single-port ring memory of DEPTH
// entries, with push, pop and peek at either end plus read and write at a
// logical index counted from the front. Each request makes at most one
// access to the ring memory at a directly computed slot, so one request is
// taken per cycle unless the output stalls stage one; results go through
// the memory read and output registers, and a finished result may wait at
// the output while the next request is taken. Refused requests (push when
// full, pop or peek when empty, index at or beyond the occupancy) leave the
// queue unchanged and report a status. The memory needs no clearing after
// reset: only slots inside the occupancy are ever read.
module deque_with_indexed_access #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = dq_pkg::ITEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mode [2:0], item [34:3], index [44:35], zero fill [47:45]
  input  logic [dq_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // item_out [31:0], occupancy [42:32], status [44:43], zero fill [47:45]
  output logic [dq_pkg::M_TDATA_W-1:0]  m_tdata
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  fire;
  mode_t                 mode;
  logic [DATA_W-1:0]     item;
  logic [IDX_W-1:0]      index;
  logic                  mem_en;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  meta_t                 meta;

  logic                  s1_valid;
  meta_t                 s1_meta;
  logic                  s1_move;

  logic                  out_valid;
  logic [DATA_W-1:0]     out_item;
  logic [OCC_W-1:0]      out_occ;
  status_t               out_status;

  // Request unpacking.
  assign mode  = mode_t'(s_tdata[MODE_W-1:0]);
  assign item  = s_tdata[MODE_W +: DATA_W];
  assign index = s_tdata[MODE_W + DATA_W +: IDX_W];

  // Stage one waits for the memory read; it moves when the output is free.
  assign s1_move  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign fire     = s_tvalid && s_tready;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (mode),
    .item      (item),
    .index     (index),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  dq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta <= meta;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; the word is taken from memory only on reads.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item   <= s1_meta.rd ? DATA_W'(mem_rdata) : '0;
      out_occ    <= s1_meta.occupancy;
      out_status <= s1_meta.status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_status, out_occ, out_item});

endmodule
